/* src/varint_decoder_assert.svh */
// ----------------------------------------------------------------------------
// varint_decoder_assert.svh - assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VARINT_DECODER_ASSERT_SVH
`define VARINT_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define VD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("varint_decoder: same-cycle check failed");
// Next-cycle implication, held off during reset.
`define VD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("varint_decoder: next-cycle check failed");
`else
`define VD_ASSERT_IMP(label, clk, rst, ante, cons)
`define VD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/vd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vd_pkg - varint decoder package
// Shared widths, register codes and the structs passed between stages.
// ----------------------------------------------------------------------------
package vd_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned GROUP_W     = 7;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned CONT_BIT    = 7;
  localparam int unsigned FULL_GROUPS = 9;
  localparam int unsigned NARROW_W    = 32;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;
  localparam logic [COUNT_W-1:0] STRADDLE_K = 4'd9;
  localparam logic [COUNT_W-1:0] OVF_MIN_K  = 4'd10;

  // register index, taken from paddr[2]
  localparam logic REG_SIGNED = 1'b0;
  localparam logic REG_NARROW = 1'b1;

  typedef struct packed {
    logic signed_mode;
    logic narrow_mode;
  } vd_cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] raw;
    logic [COUNT_W-1:0] count;
    logic               ovf;
    logic               last;
  } vd_word_t;

endpackage

/* src/vd_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vd_accum - group accumulator
// Merges one 7-bit group per step into the running value and tracks count.
// ----------------------------------------------------------------------------
module vd_accum import vd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] stream_byte,
  output vd_word_t          word
);

  logic [VALUE_W-1:0] accumulator;
  logic [COUNT_W-1:0] group_count;
  logic               overflow_seen;

  logic [VALUE_W-1:0] accumulator_next;
  logic [COUNT_W-1:0] group_count_next;
  logic               overflow_seen_next;
  logic [GROUP_W-1:0] pay;

  always_comb begin
    pay                = stream_byte[GROUP_W-1:0];
    accumulator_next   = accumulator;
    overflow_seen_next = overflow_seen;
    for (int g = 0; g < FULL_GROUPS; g++) begin
      if (group_count == COUNT_W'(g)) begin
        accumulator_next = accumulator | (VALUE_W'(pay) << (GROUP_W * g));
      end
    end
    if (group_count == STRADDLE_K) begin
      accumulator_next[VALUE_W-1] = accumulator[VALUE_W-1] | pay[0];
      if (|pay[GROUP_W-1:1]) begin
        overflow_seen_next = 1'b1;
      end
    end else if (group_count >= OVF_MIN_K) begin
      if (|pay) begin
        overflow_seen_next = 1'b1;
      end
    end
    group_count_next = (group_count == COUNT_MAX) ? COUNT_MAX : group_count + 1'b1;
  end

  assign word.raw   = accumulator_next;
  assign word.count = group_count_next;
  assign word.ovf   = overflow_seen_next;
  assign word.last  = ~stream_byte[CONT_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      group_count   <= '0;
      overflow_seen <= 1'b0;
    end else if (step) begin
      if (word.last) begin
        // value complete: start the next one from zero
        accumulator   <= '0;
        group_count   <= '0;
        overflow_seen <= 1'b0;
      end else begin
        accumulator   <= accumulator_next;
        group_count   <= group_count_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

endmodule

/* src/vd_finish.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vd_finish - value formatter
// Applies sign-in-low-bit decoding and 32-bit narrowing to a raw value.
// ----------------------------------------------------------------------------
module vd_finish import vd_pkg::*; (
  input  vd_cfg_t            cfg,
  input  logic [VALUE_W-1:0] raw,
  output logic [VALUE_W-1:0] value
);

  logic [VALUE_W-1:0] mag;
  logic [VALUE_W-1:0] wide;

  always_comb begin
    mag = raw >> 1;
    if (cfg.signed_mode) begin
      wide = raw[0] ? (VALUE_W'(0) - mag) : mag;
    end else begin
      wide = raw;
    end
    if (cfg.narrow_mode) begin
      if (cfg.signed_mode) begin
        value = {{(VALUE_W-NARROW_W){wide[NARROW_W-1]}}, wide[NARROW_W-1:0]};
      end else begin
        value = {{(VALUE_W-NARROW_W){1'b0}}, wide[NARROW_W-1:0]};
      end
    end else begin
      value = wide;
    end
  end

endmodule

/* src/varint_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_decoder - LEB128-style variable-length integer decoder
// Decodes little-endian 7-bit groups into 64-bit values, one byte per cycle while in_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / stream_byte) carries one encoded byte
//   per item; bit 7 set means another byte of the same value follows.
//   Output channel (out_valid / out_stall) carries one item per value:
//   decoded_value, byte_count (saturating at 15) and overflow.
//   An accepted byte lands in the input register, is then merged into the
//   accumulator and, if it ends a value, the result is registered in the
//   result register once that register has room; out_valid rises with it.
//   Throughput: one byte per cycle while in_stall is low; the only per-byte path
//   is the shift-OR into the accumulator followed by the 64-bit negate of signed mode.
//   Configuration: APB registers signed_mode (0x0) and narrow_mode (0x4), read
//   when a value completes. Write them only while the decoder is idle.
//   Reset clears the accumulator, both mode registers and both valid flags.
//   When the receiver stalls with a result pending, continuation bytes still
//   merge; a byte that would end the next value waits in the input register,
//   and in_stall rises only then.
// ----------------------------------------------------------------------------
module varint_decoder import vd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // byte input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  stream_byte,
  // value output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] decoded_value,
  output logic [COUNT_W-1:0] byte_count,
  output logic               overflow,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  `include "varint_decoder_assert.svh"

  vd_cfg_t            cfg;
  logic               in_q_valid;
  logic [BYTE_W-1:0]  byte_q;
  logic               in_accept;
  logic               step;
  logic               can_step;
  logic               emit;
  vd_word_t           word;
  logic [VALUE_W-1:0] finished;

  // ---------------- configuration registers ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_SIGNED: cfg.signed_mode <= pwdata[0];
        REG_NARROW: cfg.narrow_mode <= pwdata[0];
        default:    cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SIGNED: prdata = {{(DATA_W-1){1'b0}}, cfg.signed_mode};
      REG_NARROW: prdata = {{(DATA_W-1){1'b0}}, cfg.narrow_mode};
      default:    prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  // A continuation byte can always merge; a final byte needs room in the
  // result register (empty, or being taken this cycle).
  assign can_step  = ~word.last | ~out_valid | ~out_stall;
  assign step      = in_q_valid & can_step;
  assign emit      = step & word.last;
  assign in_stall  = in_q_valid & ~can_step;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      // byte consumed, nothing new behind it
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_q <= stream_byte;
    end
  end

  // ---------------- accumulate and format ----------------
  vd_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .stream_byte (byte_q),
    .word        (word)
  );

  vd_finish u_finish (
    .cfg   (cfg),
    .raw   (word.raw),
    .value (finished)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      // result taken, drop it
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      decoded_value <= finished;
      byte_count    <= word.count;
      overflow      <= word.ovf;
    end
  end

  // ---------------- checks ----------------
  `VD_ASSERT_IMP(a_stall_only_on_full, clk, rst, in_stall, out_valid && out_stall)
  `VD_ASSERT_IMP(a_count_nonzero, clk, rst, out_valid, byte_count != '0)
  `VD_ASSERT_IMP(a_ovf_needs_long, clk, rst, out_valid && overflow, byte_count >= OVF_MIN_K)
  `VD_ASSERT_NEXT(a_emit_loads, clk, rst, emit, out_valid)

endmodule

/* sim/varint_decoder_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_decoder_check - scoreboard for the varint decoder
// Watches the byte, value and configuration ports, predicts each decoded
// value from the accepted bytes and compares it with what the decoder emits.
// ----------------------------------------------------------------------------
module varint_decoder_check import vd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [BYTE_W-1:0]  stream_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [VALUE_W-1:0] decoded_value,
  input  logic [COUNT_W-1:0] byte_count,
  input  logic               overflow,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } decoded_t;

  decoded_t           due_values[$];
  logic [VALUE_W-1:0] dec_acc;
  logic [COUNT_W-1:0] dec_groups;
  logic               dec_ovf;
  logic               cfg_signed;
  logic               cfg_narrow;
  int                 err_n;
  int                 done_n;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
    err_n   = 0;
    done_n  = 0;
  end

  task automatic report(input string what, input logic [VALUE_W-1:0] got,
                        input logic [VALUE_W-1:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    err_n++;
  endtask

  // Apply the mode registers to a raw accumulator.
  function automatic logic [VALUE_W-1:0] shape_value(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] v;
    v = raw;
    if (cfg_signed) begin
      v = raw >> 1;
      if (raw[0]) v = -v;
    end
    if (cfg_narrow) v = {{32{cfg_signed & v[31]}}, v[31:0]};
    return v;
  endfunction

  task automatic take_byte(input logic [BYTE_W-1:0] b);
    logic [GROUP_W-1:0] pay;
    decoded_t           d;
    pay = b[GROUP_W-1:0];
    if (dec_groups < FULL_GROUPS) begin
      dec_acc |= {57'd0, pay} << (GROUP_W * dec_groups);
    end else if (dec_groups == FULL_GROUPS) begin
      // straddling group: only its low bit fits at bit 63
      dec_acc[VALUE_W-1] = dec_acc[VALUE_W-1] | pay[0];
      if (pay[GROUP_W-1:1] != '0) dec_ovf = 1'b1;
    end else if (pay != '0) begin
      dec_ovf = 1'b1;
    end
    if (dec_groups != COUNT_MAX) dec_groups++;
    if (!b[CONT_BIT]) begin
      d.value = shape_value(dec_acc);
      d.count = dec_groups;
      d.ovf   = dec_ovf;
      due_values.push_back(d);
      dec_acc    = '0;
      dec_groups = '0;
      dec_ovf    = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    decoded_t d;
    if (rst) begin
      due_values.delete();
      dec_acc    = '0;
      dec_groups = '0;
      dec_ovf    = 1'b0;
      cfg_signed = 1'b0;
      cfg_narrow = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_values.size() == 0) begin
          report("unexpected value", decoded_value, '0);
        end else begin
          d = due_values.pop_front();
          done_n++;
          if (decoded_value !== d.value) report("decoded_value", decoded_value, d.value);
          if (byte_count !== d.count) begin
            report("byte_count", VALUE_W'(byte_count), VALUE_W'(d.count));
          end
          if (overflow !== d.ovf) report("overflow", VALUE_W'(overflow), VALUE_W'(d.ovf));
        end
      end
      if (in_valid && !in_stall) take_byte(stream_byte);
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_SIGNED: cfg_signed = pwdata[0];
          REG_NARROW: cfg_narrow = pwdata[0];
          default: ;
        endcase
      end
    end
    errors  <= err_n;
    pending <= due_values.size();
    checked <= done_n;
  end

endmodule

/* sim/varint_decoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_decoder_test - top of the varint decoder testbench
// Feeds directed and random varint byte streams under all four mode settings,
// with random gaps and stalls on both channels, and reports the verdict of
// the attached scoreboard.
// ----------------------------------------------------------------------------
module varint_decoder_test;
  import vd_pkg::*;

  // quiet cycles tolerated before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // cycles to let the decoder pipeline drain (input and result registers plus margin)
  localparam int DRAIN = 4;
  localparam int PHASES = 5;
  localparam int PHASE_BYTES = 330;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [BYTE_W-1:0]  stream_byte;
  logic               out_valid;
  logic               out_stall;
  logic [VALUE_W-1:0] decoded_value;
  logic [COUNT_W-1:0] byte_count;
  logic               overflow;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int errors;
  int pending;
  int checked;
  int idle_pct;
  int stall_pct;
  int bytes_sent;
  int quiet_cycles;

  // mode settings of the random phases; the last phase runs without gaps
  bit sgn_tab[PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
  bit nar_tab[PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
  int pct_tab[PHASES] = '{37, 37, 37, 37, 0};

  varint_decoder DUT (.*);

  varint_decoder_check CHECK (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .stream_byte(stream_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .decoded_value(decoded_value), .byte_count(byte_count), .overflow(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending), .checked(checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Every input is known from time zero; reset is held from the start.
  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    stream_byte = '0;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_pct    = 37;
    stall_pct   = 37;
    bytes_sent  = 0;
  end

  // Receiver side: stall at random on every cycle, whether or not a value waits.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: count cycles with no handshake on any port.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial quiet_cycles = 0;

  // Offer one byte, after a random gap, and hold it until it is accepted.
  // in_valid stays high from one item to the next unless a gap is drawn.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Setup cycle, then access cycle; the register takes the data at the edge
  // that ends the access cycle.
  task automatic apb_write(input logic idx, input bit v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // upper data bits are don't-care for one-bit registers; randomize them
    pwdata  <= {$urandom} & ~32'd1 | {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop the input, let all results out and the pipeline settle, then write
  // both mode registers.
  task automatic set_modes(input bit sgn, input bit nar);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    apb_write(REG_SIGNED, sgn);
    apb_write(REG_NARROW, nar);
  endtask

  // One random value. Most are well-formed encodings of 1 to 10 bytes; some
  // run past the tenth group to hit the straddle, overflow and count
  // saturation; the rest are raw bytes until one happens to end the value.
  task automatic send_value();
    int unsigned        shape;
    int unsigned        len;
    int unsigned        fill;
    int unsigned        i;
    bit                 clean_top;
    logic [GROUP_W-1:0] pay;
    logic [BYTE_W-1:0]  b;
    shape = $urandom_range(99);
    if (shape < 10) begin
      do begin
        b = BYTE_W'($urandom);
        send_byte(b);
      end while (b[CONT_BIT]);
    end else begin
      if (shape < 75) len = $urandom_range(1, 10);
      else len = $urandom_range(11, 20);
      fill      = $urandom_range(3);
      clean_top = 1'($urandom_range(1));
      for (i = 0; i < len; i++) begin
        case (fill)
          0: pay = '0;
          1: pay = '1;
          default: pay = GROUP_W'($urandom);
        endcase
        // clean top: keep only what fits in 64 bits, so no overflow is flagged
        if (clean_top && i == FULL_GROUPS) pay = GROUP_W'($urandom_range(1));
        if (clean_top && i > FULL_GROUPS) pay = '0;
        send_byte({i != len - 1, pay});
      end
    end
  endtask

  initial begin
    int p;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, unsigned wide mode after reset.
    set_modes(1'b0, 1'b0);
    send_byte(8'h00);                  // zero in one byte
    send_byte(8'h7F);                  // largest one-byte value
    send_byte(8'h80);                  // 128: empty low group
    send_byte(8'h01);
    // straddling group with all payload bits set: bit 63 kept, rest flagged
    repeat (FULL_GROUPS) send_byte(8'hFF);
    send_byte(8'h7F);
    // modes change between the bytes of one value; the new ones must apply
    send_byte(8'hC5);
    set_modes(1'b1, 1'b1);
    send_byte(8'h7F);

    // Random phases over all mode settings.
    for (p = 0; p < PHASES; p++) begin
      set_modes(sgn_tab[p], nar_tab[p]);
      idle_pct  = pct_tab[p];
      stall_pct = pct_tab[p];
      while (bytes_sent < PHASE_BYTES * (p + 1)) send_value();
    end

    // Drain and settle before the verdict.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * DRAIN) @(posedge clk);

    $display("covered %0d bytes and %0d decoded values in all four sign and width modes",
             bytes_sent, checked);
    $display("including long and overflowing values, random gaps and stalls on both sides");
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
